// ----- design/prince_block_encrypt_core_macros.svh -----
// assertion macros for the prince core top level
`ifndef PRINCE_BLOCK_ENCRYPT_CORE_MACROS_SVH
`define PRINCE_BLOCK_ENCRYPT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PRINCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRINCE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRINCE_ASSERT(label, prop, msg)
`define PRINCE_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- design/prince_pkg.sv -----
// constants, tables and layer functions for the prince core
`default_nettype none

package prince_pkg;

    localparam int BLOCK_W = 64;
    localparam int NIBBLES = 16;
    localparam int ROUNDS_FULL = 5;
    localparam int CELL_COUNT = 2 * ROUNDS_FULL + 1;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [1:0] {
        CELL_FWD,
        CELL_MID,
        CELL_BWD
    } cell_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WHITENING_KEY = 2'd0,
        REG_CORE_KEY      = 2'd1,
        REG_REDUCED_MODE  = 2'd2
    } cfg_reg_t;

    localparam logic [3:0] SB_FWD [NIBBLES] = '{
        4'hb, 4'hf, 4'h3, 4'h2, 4'ha, 4'hc, 4'h9, 4'h1,
        4'h6, 4'h7, 4'h8, 4'h0, 4'he, 4'h5, 4'hd, 4'h4
    };
    localparam logic [3:0] SB_INV [NIBBLES] = '{
        4'hb, 4'h7, 4'h3, 4'h2, 4'hf, 4'hd, 4'h8, 4'h9,
        4'ha, 4'h6, 4'h4, 4'h0, 4'h5, 4'he, 4'hc, 4'h1
    };
    localparam logic [3:0] SR_FWD [NIBBLES] = '{
        4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
        4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
    };
    localparam logic [3:0] SR_INV [NIBBLES] = '{
        4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
        4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3
    };
    localparam logic [BLOCK_W-1:0] RC [ROUNDS_FULL+1] = '{
        64'h0000000000000000, 64'h13198a2e03707344, 64'ha4093822299f31d0,
        64'h082efa98ec4e6c89, 64'h452821e638d01377, 64'hbe5466cf34e90c6c
    };
    localparam logic [BLOCK_W-1:0] RC_ALPHA = 64'hc0ac29b7c97c50dd;

    // nibble 0 sits in the top bits
    function automatic logic [3:0] nib(input logic [BLOCK_W-1:0] s, input int i);
        return s[BLOCK_W-1-4*i -: 4];
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < NIBBLES; i++)
            r[BLOCK_W-1-4*i -: 4] = SB_FWD[nib(s, i)];
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < NIBBLES; i++)
            r[BLOCK_W-1-4*i -: 4] = SB_INV[nib(s, i)];
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] shift_fwd(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < NIBBLES; i++)
            r[BLOCK_W-1-4*i -: 4] = nib(s, int'(SR_FWD[i]));
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] shift_inv(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < NIBBLES; i++)
            r[BLOCK_W-1-4*i -: 4] = nib(s, int'(SR_INV[i]));
        return r;
    endfunction

    // m' layer: m0 on columns 0 and 3, m1 (rows rotated by one) on columns 1 and 2
    function automatic logic [BLOCK_W-1:0] mix(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        logic [3:0] x0, x1, x2, x3, a, b, c, d;
        logic [3:0] y [4];
        for (int col = 0; col < 4; col++) begin
            x0 = nib(s, 4*col);
            x1 = nib(s, 4*col + 1);
            x2 = nib(s, 4*col + 2);
            x3 = nib(s, 4*col + 3);
            a = x1 ^ x2 ^ x3;
            b = x0 ^ x2 ^ x3;
            c = x0 ^ x1 ^ x3;
            d = x0 ^ x1 ^ x2;
            y[0] = {a[3], b[2], c[1], d[0]};
            y[1] = {d[3], a[2], b[1], c[0]};
            y[2] = {c[3], d[2], a[1], b[0]};
            y[3] = {b[3], c[2], d[1], a[0]};
            for (int j = 0; j < 4; j++) begin
                if (col == 1 || col == 2)
                    r[BLOCK_W-1-4*(4*col+j) -: 4] = y[(j + 1) % 4];
                else
                    r[BLOCK_W-1-4*(4*col+j) -: 4] = y[j];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/prince_cell.sv -----
// one round cell of the prince pipeline
`default_nettype none

module prince_cell #(
    parameter prince_pkg::cell_kind_t KIND = prince_pkg::CELL_FWD,
    parameter int RC_INDEX = 1
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            advance,
    input  wire logic                            active,
    input  wire logic [prince_pkg::BLOCK_W-1:0]  core_key,
    input  wire logic                            valid_in,
    input  wire logic [prince_pkg::BLOCK_W-1:0]  state_in,
    output logic                                 valid_out,
    output logic      [prince_pkg::BLOCK_W-1:0]  state_out
);

    logic                           valid_reg;
    logic [prince_pkg::BLOCK_W-1:0] state_reg;
    logic [prince_pkg::BLOCK_W-1:0] state_next;
    logic [prince_pkg::BLOCK_W-1:0] round_out;

    always_comb
    begin
        case (KIND)
            prince_pkg::CELL_FWD:
                round_out = prince_pkg::shift_fwd(prince_pkg::mix(prince_pkg::sub_fwd(state_in)))
                            ^ core_key ^ prince_pkg::RC[RC_INDEX];
            prince_pkg::CELL_MID:
                round_out = prince_pkg::sub_inv(prince_pkg::mix(prince_pkg::sub_fwd(state_in)));
            prince_pkg::CELL_BWD:
                round_out = prince_pkg::sub_inv(prince_pkg::mix(prince_pkg::shift_inv(
                            state_in ^ core_key ^ prince_pkg::RC[RC_INDEX]
                            ^ prince_pkg::RC_ALPHA)));
            default:
                round_out = state_in;
        endcase
        // rounds outside the reduced cipher just pass the block on
        state_next = active ? round_out : state_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

`default_nettype wire

// ----- design/prince_block_encrypt_core.sv -----
// top level of the prince block encryption core: config, cell chain, output register
//
//  channel  | direction | handshake                 | payload
//  plain    | in        | plain_valid / plain_stall   | plain_block[63:0]
//  cipher   | out       | cipher_valid / cipher_stall | cipher_block[63:0]
//  cfg      | in        | cfg_write                 | cfg_index[1:0], cfg_data[63:0]
//
// one block accepted per cycle while plain_stall is low; each result passes through
// the 11 round cells and the output register, in both full and reduced mode
// the whole chain moves together and halts only while a result waits under cipher_stall
// reset clears keys, mode and all valid flags; no clearing pass is needed
`default_nettype none
`include "prince_block_encrypt_core_macros.svh"

module prince_block_encrypt_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [prince_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [prince_pkg::BLOCK_W-1:0]       cfg_data,
    input  wire logic                                 plain_valid,
    output logic                                      plain_stall,
    input  wire logic [prince_pkg::BLOCK_W-1:0]       plain_block,
    output logic                                      cipher_valid,
    input  wire logic                                 cipher_stall,
    output logic      [prince_pkg::BLOCK_W-1:0]       cipher_block
);

    localparam int N = prince_pkg::CELL_COUNT;
    localparam int R = prince_pkg::ROUNDS_FULL;

    logic [prince_pkg::BLOCK_W-1:0] whitening_key_reg;
    logic [prince_pkg::BLOCK_W-1:0] core_key_reg;
    logic                           reduced_mode_reg;
    logic                           out_valid_reg;
    logic [prince_pkg::BLOCK_W-1:0] out_block_reg;
    logic [prince_pkg::BLOCK_W-1:0] out_block_next;
    logic [prince_pkg::BLOCK_W-1:0] k0_prime;
    logic                           advance;

    logic                           valid_chain [N+1];
    logic [prince_pkg::BLOCK_W-1:0] state_chain [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whitening_key_reg <= '0;
            core_key_reg      <= '0;
            reduced_mode_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                prince_pkg::REG_WHITENING_KEY: whitening_key_reg <= cfg_data;
                prince_pkg::REG_CORE_KEY:      core_key_reg      <= cfg_data;
                prince_pkg::REG_REDUCED_MODE:  reduced_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign advance     = !(out_valid_reg && cipher_stall);
    assign plain_stall = !advance;

    // entry whitening with k0, k1 and the zero round constant
    assign valid_chain[0] = plain_valid;
    assign state_chain[0] = plain_block ^ whitening_key_reg ^ core_key_reg
                            ^ prince_pkg::RC[0];

    generate
        for (genvar g = 0; g < N; g++)
        begin : g_cell
            localparam prince_pkg::cell_kind_t KIND_G =
                (g < R) ? prince_pkg::CELL_FWD :
                (g == R) ? prince_pkg::CELL_MID : prince_pkg::CELL_BWD;
            localparam int RC_G = (g < R) ? g + 1 : (g == R) ? 1 : N - g;
            logic active;

            // the reduced cipher keeps only the middle cell and the rounds that use constant RC[1]
            assign active = (KIND_G == prince_pkg::CELL_MID) || (RC_G == 1) || !reduced_mode_reg;

            prince_cell #(
                .KIND     (KIND_G),
                .RC_INDEX (RC_G)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .active    (active),
                .core_key  (core_key_reg),
                .valid_in  (valid_chain[g]),
                .state_in  (state_chain[g]),
                .valid_out (valid_chain[g+1]),
                .state_out (state_chain[g+1])
            );
        end
    endgenerate

    // k0' = (k0 >>> 1) ^ (k0 >> 63)
    assign k0_prime = {whitening_key_reg[0], whitening_key_reg[prince_pkg::BLOCK_W-1:1]}
                      ^ {{(prince_pkg::BLOCK_W-1){1'b0}},
                         whitening_key_reg[prince_pkg::BLOCK_W-1]};

    assign out_block_next = state_chain[N] ^ core_key_reg ^ prince_pkg::RC[0]
                            ^ prince_pkg::RC_ALPHA ^ k0_prime;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= valid_chain[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_block_reg <= out_block_next;
        end
    end

    assign cipher_valid = out_valid_reg;
    assign cipher_block = out_block_reg;

    `PRINCE_ASSERT(a_last_cell_lands, advance && valid_chain[N] |=> cipher_valid, "finished block not presented")
    `PRINCE_ASSERT(a_no_phantom, advance && !valid_chain[N] |=> !cipher_valid, "result without a request")
    `PRINCE_ASSERT(a_stall_only_when_full, plain_stall |-> cipher_valid && cipher_stall, "chain halted with room at output")
    `PRINCE_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !cipher_valid, "output valid during reset")

endmodule

`default_nettype wire

// ----- tb/prince_block_encrypt_core_checker.sv -----
`timescale 1ns / 1ps
// checker for the prince core: tracks key writes, predicts each cipher block and compares

module prince_block_encrypt_core_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [prince_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [prince_pkg::BLOCK_W-1:0]      cfg_data,
    input  wire logic                                plain_valid,
    input  wire logic                                plain_stall,
    input  wire logic [prince_pkg::BLOCK_W-1:0]      plain_block,
    input  wire logic                                cipher_valid,
    input  wire logic                                cipher_stall,
    input  wire logic [prince_pkg::BLOCK_W-1:0]      cipher_block,
    output int                                       error_count,
    output int                                       pending_count,
    output int                                       checked_count
);

    typedef struct packed {
        logic [63:0] plain;
        logic [63:0] cipher;
    } block_pair_t;

    localparam logic [3:0] SBOX [16] = '{
        4'hb, 4'hf, 4'h3, 4'h2, 4'ha, 4'hc, 4'h9, 4'h1,
        4'h6, 4'h7, 4'h8, 4'h0, 4'he, 4'h5, 4'hd, 4'h4
    };
    localparam logic [3:0] SBOX_INV [16] = '{
        4'hb, 4'h7, 4'h3, 4'h2, 4'hf, 4'hd, 4'h8, 4'h9,
        4'ha, 4'h6, 4'h4, 4'h0, 4'h5, 4'he, 4'hc, 4'h1
    };
    localparam int ROW_SHIFT [16] = '{0, 5, 10, 15, 4, 9, 14, 3, 8, 13, 2, 7, 12, 1, 6, 11};
    localparam int ROW_UNSHIFT [16] = '{0, 13, 10, 7, 4, 1, 14, 11, 8, 5, 2, 15, 12, 9, 6, 3};
    localparam logic [63:0] ROUND_CONST [6] = '{
        64'h0000000000000000, 64'h13198a2e03707344, 64'ha4093822299f31d0,
        64'h082efa98ec4e6c89, 64'h452821e638d01377, 64'hbe5466cf34e90c6c
    };
    localparam logic [63:0] ALPHA = 64'hc0ac29b7c97c50dd;

    logic [63:0] whiten_key;
    logic [63:0] round_key;
    logic        reduced;
    block_pair_t expected_blocks [$];

    function automatic logic [63:0] substitute(input logic [63:0] s, input bit inverse);
        logic [63:0] r;
        for (int i = 0; i < 16; i++)
            r[63-4*i -: 4] = inverse ? SBOX_INV[s[63-4*i -: 4]] : SBOX[s[63-4*i -: 4]];
        return r;
    endfunction

    function automatic logic [63:0] shift_rows(input logic [63:0] s, input bit inverse);
        logic [63:0] r;
        int src;
        for (int i = 0; i < 16; i++) begin
            src = inverse ? ROW_UNSHIFT[i] : ROW_SHIFT[i];
            r[63-4*i -: 4] = s[63-4*src -: 4];
        end
        return r;
    endfunction

    // each output bit is the xor of the other three nibbles of the column;
    // columns 1 and 2 take the rows rotated by one
    function automatic logic [63:0] mix_columns(input logic [63:0] s);
        logic [63:0] r;
        logic [3:0]  x [4];
        logic [3:0]  t [4];
        logic [3:0]  y [4];
        logic [3:0]  col_sum;
        int          rot;
        for (int col = 0; col < 4; col++) begin
            col_sum = 4'h0;
            for (int j = 0; j < 4; j++) begin
                x[j] = s[63-16*col-4*j -: 4];
                col_sum = col_sum ^ x[j];
            end
            for (int j = 0; j < 4; j++)
                t[j] = col_sum ^ x[j];
            for (int j = 0; j < 4; j++) begin
                y[j] = 4'h0;
                for (int k = 0; k < 4; k++)
                    y[j] = y[j] | (t[(k - j) & 3] & (4'b1000 >> k));
            end
            rot = (col == 1 || col == 2) ? 1 : 0;
            for (int j = 0; j < 4; j++)
                r[63-16*col-4*j -: 4] = y[(j + rot) & 3];
        end
        return r;
    endfunction

    function automatic logic [63:0] encipher(input logic [63:0] blk);
        logic [63:0] s;
        logic [63:0] outer_key;
        int          rounds;
        outer_key = {whiten_key[0], whiten_key[63:1]} ^ {63'd0, whiten_key[63]};
        rounds = reduced ? 1 : 5;
        s = blk ^ whiten_key ^ round_key ^ ROUND_CONST[0];
        for (int i = 1; i <= rounds; i++) begin
            s = substitute(s, 1'b0);
            s = shift_rows(mix_columns(s), 1'b0);
            s = s ^ round_key ^ ROUND_CONST[i];
        end
        s = substitute(mix_columns(substitute(s, 1'b0)), 1'b1);
        for (int i = rounds; i >= 1; i--) begin
            s = s ^ round_key ^ ROUND_CONST[i] ^ ALPHA;
            s = substitute(mix_columns(shift_rows(s, 1'b1)), 1'b1);
        end
        s = s ^ round_key ^ ROUND_CONST[0] ^ ALPHA;
        return s ^ outer_key;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        block_pair_t head;
        if (!rst_n) begin
            whiten_key = '0;
            round_key = '0;
            reduced = 1'b0;
            expected_blocks.delete();
            error_count = 0;
            checked_count = 0;
            pending_count = 0;
        end else begin
            if (cipher_valid && !cipher_stall) begin
                if (expected_blocks.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("cipher block %h with no request outstanding", cipher_block);
                end else begin
                    head = expected_blocks.pop_front();
                    checked_count++;
                    if (cipher_block !== head.cipher) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("cipher mismatch: plain %h expected %h got %h",
                                     head.plain, head.cipher, cipher_block);
                    end
                end
            end
            if (plain_valid && !plain_stall)
                expected_blocks.push_back('{plain: plain_block, cipher: encipher(plain_block)});
            if (cfg_write) begin
                case (prince_pkg::cfg_reg_t'(cfg_index))
                    prince_pkg::REG_WHITENING_KEY: whiten_key = cfg_data;
                    prince_pkg::REG_CORE_KEY:      round_key = cfg_data;
                    prince_pkg::REG_REDUCED_MODE:  reduced = cfg_data[0];
                    default: ;
                endcase
            end
            pending_count = expected_blocks.size();
        end
    end

endmodule

// ----- tb/prince_block_encrypt_core_test.sv -----
`timescale 1ns / 1ps
// top of the prince core testbench: clock, reset, key settings, block traffic and verdict

module prince_block_encrypt_core_test;

    localparam logic [prince_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int IDLE_GUARD = 14;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BLOCKS = 107;
    localparam int LONG_HOLD = 200;
    localparam logic [63:0] CORNER_BLOCKS [8] = '{
        64'h0000000000000000, 64'hffffffffffffffff, 64'h0123456789abcdef,
        64'hfedcba9876543210, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
        64'h8000000000000001, 64'h0000000100000000
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        plain_valid;
    logic        plain_stall;
    logic [63:0] plain_block;
    logic        cipher_valid;
    logic        cipher_stall;
    logic [63:0] cipher_block;

    int error_count;
    int pending_count;
    int checked_count;
    int cycles;
    int blocks_sent;
    int settings_used;
    int long_holds;
    bit tx_jitter;
    bit rx_jitter;

    prince_block_encrypt_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .plain_valid  (plain_valid),
        .plain_stall  (plain_stall),
        .plain_block  (plain_block),
        .cipher_valid (cipher_valid),
        .cipher_stall (cipher_stall),
        .cipher_block (cipher_block)
    );

    prince_block_encrypt_core_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .plain_valid   (plain_valid),
        .plain_stall   (plain_stall),
        .plain_block   (plain_block),
        .cipher_valid  (cipher_valid),
        .cipher_stall  (cipher_stall),
        .cipher_block  (cipher_block),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial cycles = 0;
    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // mostly dense random words, with zeros, ones, one-hot, one-cold and repeated nibbles mixed in
    function automatic logic [63:0] draw_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            3: return ~(64'd1 << $urandom_range(0, 63));
            4: return {16{4'($urandom_range(0, 15))}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_block(input logic [63:0] blk);
        int gap;
        gap = tx_jitter ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            plain_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        plain_valid <= 1'b1;
        plain_block <= blk;
        do @(posedge clk); while (!(plain_valid && !plain_stall));
        blocks_sent++;
    endtask

    // every request yields a result, so an empty queue means the core is idle
    task automatic drain();
        plain_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    task automatic configure(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] mode_word, input bit spare_write);
        logic [1:0]  idx [4];
        logic [63:0] val [4];
        int          n;
        idx[0] = prince_pkg::REG_WHITENING_KEY;
        idx[1] = prince_pkg::REG_CORE_KEY;
        idx[2] = prince_pkg::REG_REDUCED_MODE;
        idx[3] = CFG_SPARE_INDEX;
        val[0] = k0;
        val[1] = k1;
        val[2] = mode_word;
        val[3] = draw_word();
        n = spare_write ? 4 : 3;
        for (int i = 0; i < n; i++) begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // result side: short random stalls in bursts, and two long hold-offs that back up the core
    initial begin
        int taken;
        int stalls;
        taken = 0;
        rx_jitter = 1'b1;
        long_holds = 0;
        cipher_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (taken == 450 || taken == 1000) begin
                stalls = LONG_HOLD;
                long_holds++;
            end else begin
                stalls = rx_jitter ? $urandom_range(0, 4) : 0;
            end
            if (stalls > 0) begin
                cipher_stall <= 1'b1;
                repeat (stalls) @(posedge clk);
                cipher_stall <= 1'b0;
            end
            do @(posedge clk); while (!(cipher_valid && !cipher_stall));
            taken++;
            if (taken % 97 == 0)
                rx_jitter = $urandom_range(0, 3) != 0;
        end
    end

    initial begin
        blocks_sent = 0;
        settings_used = 0;
        tx_jitter = 1'b1;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= prince_pkg::REG_WHITENING_KEY;
        cfg_data <= '0;
        plain_valid <= 1'b0;
        plain_block <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keys and mode as left by reset
        for (int i = 0; i < 8; i++)
            send_block(CORNER_BLOCKS[i]);
        drain();

        // all-ones keys, full cipher
        configure('1, '1, 64'd0, 1'b0);
        for (int i = 0; i < 4; i++)
            send_block(CORNER_BLOCKS[i]);
        drain();

        // top bit of k0 wraps into k0'; reduced mode written with all upper bits set
        configure(64'h8000000000000001, 64'h0123456789abcdef, '1, 1'b0);
        for (int i = 4; i < 8; i++)
            send_block(CORNER_BLOCKS[i]);
        drain();

        // full mode with junk above bit 0, then a write to the unused index
        configure(64'h0000000000000001, '0, 64'hfffffffffffffffe, 1'b1);
        for (int i = 0; i < 4; i++)
            send_block(CORNER_BLOCKS[i]);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            configure(draw_word(), draw_word(),
                      {{$urandom, $urandom} & 64'hfffffffffffffffe} | 64'(ph % 2),
                      $urandom_range(0, 2) == 0);
            tx_jitter = (ph % 3) != 0;
            for (int i = 0; i < PHASE_BLOCKS; i++)
                send_block(draw_word());
            drain();
        end

        $display("covered %0d blocks over %0d key and mode settings, %0d results checked",
                 blocks_sent, settings_used, checked_count);
        $display("full and reduced rounds exercised, %0d long result hold-offs", long_holds);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
